/* hdl/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rgbbr_pkg.sv */
// Package with widths and payload types of the RGB brightness rescaler.
`timescale 1ns / 1ps
`default_nettype none
package rgbbr_pkg;
    localparam int COMPONENT_BITS = 8;
    localparam int HUE_Q_W        = 7;   // hue quotient never exceeds 120

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red_in;
        logic [COMPONENT_BITS-1:0] green_in;
        logic [COMPONENT_BITS-1:0] blue_in;
        logic [COMPONENT_BITS-1:0] brightness;
    } rgbbr_in_t;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red_out;
        logic [COMPONENT_BITS-1:0] green_out;
        logic [COMPONENT_BITS-1:0] blue_out;
    } rgbbr_out_t;
endpackage
`default_nettype wire

/* hdl/rgbbr_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rgbbr_div_pipe #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo
);
    localparam int EXT_W = DEN_W + Q_W + 1;

    logic [EXT_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        localparam int BIT = Q_W - 1 - i;
        logic [EXT_W-1:0] rem_in, shifted, rem_next;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in, quo_next;
        logic             ge;

        if (i == 0) begin : g_first
            assign rem_in = {{(EXT_W-NUM_W){1'b0}}, num};
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        always_comb begin
            shifted  = {{(EXT_W-DEN_W){1'b0}}, den_in} << BIT;
            ge       = (rem_in >= shifted);
            rem_next = ge ? (rem_in - shifted) : rem_in;
            quo_next = quo_in;
            quo_next[BIT] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];
endmodule
`default_nettype wire

/* hdl/rgb_brightness_rescale_top.sv */
// Top level of the RGB brightness rescaler: hue/saturation kept, value replaced.
`timescale 1ns / 1ps
`default_nettype none
//  channel | direction | payload          | handshake
//  s_      | in        | r, g, b, bright  | s_valid / s_ready
//  m_      | out       | r, g, b          | m_valid / m_ready
//
//  One transaction per clock sustained unless m_ready stalls the output; the
//  pipe holds the 7-stage hue divider followed by the COMPONENT_BITS-stage
//  divider for p, q and t.
//  Reset (aresetn low, synchronous) clears only the valid bits.
//  A stall on m_ready freezes every stage at once; nothing is lost or repeated.
module rgb_brightness_rescale_top
    import rgbbr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire rgbbr_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output rgbbr_out_t      m_data
);
    localparam int W      = COMPONENT_BITS;
    localparam int HNUM_W = W + 7;          // up to 120 * d
    localparam int DEN6_W = W + 6;          // 60 * max
    localparam int QNUM_W = W + DEN6_W;
    localparam int LAT    = HUE_Q_W + W + 5;

    // which channel holds the maximum, red split by sign of g - b
    localparam logic [1:0] SEL_RPOS  = 2'd0;
    localparam logic [1:0] SEL_RNEG  = 2'd1;
    localparam logic [1:0] SEL_GREEN = 2'd2;
    localparam logic [1:0] SEL_BLUE  = 2'd3;

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;

    typedef struct packed {
        logic [W-1:0] v;
        logic [W-1:0] mx;
        logic [W-1:0] mn;
        logic [W-1:0] d;
        logic [1:0]   sel;
        logic         grey;
    } side_t;

    typedef struct packed {
        logic [W-1:0] v;
        logic [2:0]   sector;
        logic         grey;
    } tail_t;

    logic           en;
    logic [LAT-1:0] valid_reg;

    // Advance the whole pipe unless the output holds an untaken transaction.
    assign en      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    // ---- stage 1: max, min, delta and hue numerator ----
    logic [W-1:0]      r, g, b, mx, mn, d;
    logic [1:0]        sel;
    logic [W:0]        span;
    logic [HNUM_W-1:0] a_next;
    side_t             s1_side_reg;
    logic [HNUM_W-1:0] s1_a_reg;

    always_comb begin
        r  = s_data.red_in;
        g  = s_data.green_in;
        b  = s_data.blue_in;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (mx == r) begin
            sel = (g >= b) ? SEL_RPOS : SEL_RNEG;
        end else if (mx == g) begin
            sel = SEL_GREEN;
        end else begin
            sel = SEL_BLUE;
        end
        // Shift green and blue sectors by 60 so the numerator stays non-negative.
        case (sel)
            SEL_RPOS:  span = {1'b0, g} - {1'b0, b};
            SEL_RNEG:  span = {1'b0, b} - {1'b0, g};
            SEL_GREEN: span = {1'b0, b} + {1'b0, d} - {1'b0, r};
            default:   span = {1'b0, r} + {1'b0, d} - {1'b0, g};
        endcase
        a_next = HNUM_W'(span) * HNUM_W'(60);
        // ceil for the wrapped red case
        if (sel == SEL_RNEG) a_next = a_next + HNUM_W'(d) - HNUM_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= '{v: s_data.brightness, mx: mx, mn: mn, d: d,
                             sel: sel, grey: (d == '0)};
            s1_a_reg    <= a_next;
        end
    end

    // ---- hue divider, side data delayed alongside ----
    logic [HUE_Q_W-1:0] hq;
    side_t              hd_side_reg [HUE_Q_W];

    rgbbr_div_pipe #(.NUM_W(HNUM_W), .DEN_W(W), .Q_W(HUE_Q_W)) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (s1_a_reg),
        .den  (s1_side_reg.d),
        .quo  (hq)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            hd_side_reg[0] <= s1_side_reg;
            for (int i = 1; i < HUE_Q_W; i++) hd_side_reg[i] <= hd_side_reg[i-1];
        end
    end

    // ---- stage H: hue, sector and remainder ----
    side_t        hs;
    logic [8:0]   hue;
    logic [2:0]   sector;
    logic [8:0]   base;
    side_t        h_side_reg;
    logic [2:0]   h_sector_reg;
    logic [5:0]   h_k_reg;

    always_comb begin
        hs = hd_side_reg[HUE_Q_W-1];
        case (hs.sel)
            SEL_RPOS:  hue = 9'(hq);
            SEL_RNEG:  hue = 9'd360 - 9'(hq);
            SEL_GREEN: hue = 9'd60 + 9'(hq);
            default:   hue = 9'd180 + 9'(hq);
        endcase
        if      (hue < 9'd60)  begin sector = SECT_0; base = 9'd0;   end
        else if (hue < 9'd120) begin sector = SECT_1; base = 9'd60;  end
        else if (hue < 9'd180) begin sector = SECT_2; base = 9'd120; end
        else if (hue < 9'd240) begin sector = SECT_3; base = 9'd180; end
        else if (hue < 9'd300) begin sector = SECT_4; base = 9'd240; end
        else                   begin sector = SECT_5; base = 9'd300; end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_side_reg   <= hs;
            h_sector_reg <= sector;
            h_k_reg      <= 6'(hue - base);
        end
    end

    // ---- stage H2: delta products and denominator ----
    logic [DEN6_W-1:0] dk_reg, dk2_reg, den2_reg;
    logic [2*W-1:0]    pnum2_reg;
    tail_t             t2_reg;
    logic [W-1:0]      mx2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dk_reg    <= DEN6_W'(h_side_reg.d) * DEN6_W'(h_k_reg);
            dk2_reg   <= DEN6_W'(h_side_reg.d) * DEN6_W'(6'd60 - h_k_reg);
            den2_reg  <= DEN6_W'(h_side_reg.mx) * DEN6_W'(60);
            pnum2_reg <= (2*W)'(h_side_reg.v) * (2*W)'(h_side_reg.mn);
            mx2_reg   <= h_side_reg.mx;
            t2_reg    <= '{v: h_side_reg.v, sector: h_sector_reg, grey: h_side_reg.grey};
        end
    end

    // ---- stage H3: numerators for q and t ----
    logic [QNUM_W-1:0] qnum_reg, tnum_reg;
    logic [DEN6_W-1:0] den3_reg;
    logic [2*W-1:0]    pnum3_reg;
    logic [W-1:0]      mx3_reg;
    tail_t             t3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qnum_reg  <= QNUM_W'(t2_reg.v) * QNUM_W'(den2_reg - dk_reg);
            tnum_reg  <= QNUM_W'(t2_reg.v) * QNUM_W'(den2_reg - dk2_reg);
            den3_reg  <= den2_reg;
            pnum3_reg <= pnum2_reg;
            mx3_reg   <= mx2_reg;
            t3_reg    <= t2_reg;
        end
    end

    // ---- p, q, t dividers ----
    logic [W-1:0] p, q, t;
    tail_t        td_reg [W];

    rgbbr_div_pipe #(.NUM_W(2*W), .DEN_W(W), .Q_W(W)) u_p_div (
        .aclk (aclk), .en (en), .num (pnum3_reg), .den (mx3_reg), .quo (p)
    );
    rgbbr_div_pipe #(.NUM_W(QNUM_W), .DEN_W(DEN6_W), .Q_W(W)) u_q_div (
        .aclk (aclk), .en (en), .num (qnum_reg), .den (den3_reg), .quo (q)
    );
    rgbbr_div_pipe #(.NUM_W(QNUM_W), .DEN_W(DEN6_W), .Q_W(W)) u_t_div (
        .aclk (aclk), .en (en), .num (tnum_reg), .den (den3_reg), .quo (t)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            td_reg[0] <= t3_reg;
            for (int i = 1; i < W; i++) td_reg[i] <= td_reg[i-1];
        end
    end

    // ---- output stage: place V, p, q, t by sector; grey gives V everywhere ----
    tail_t      tl;
    rgbbr_out_t out_next;
    rgbbr_out_t out_reg;

    always_comb begin
        tl = td_reg[W-1];
        case (tl.sector)
            SECT_1:  out_next = '{red_out: q,    green_out: tl.v, blue_out: p};
            SECT_2:  out_next = '{red_out: p,    green_out: tl.v, blue_out: t};
            SECT_3:  out_next = '{red_out: p,    green_out: q,    blue_out: tl.v};
            SECT_4:  out_next = '{red_out: t,    green_out: p,    blue_out: tl.v};
            SECT_5:  out_next = '{red_out: tl.v, green_out: p,    blue_out: q};
            default: out_next = '{red_out: tl.v, green_out: t,    blue_out: p};
        endcase
        if (tl.grey) out_next = '{red_out: tl.v, green_out: tl.v, blue_out: tl.v};
    end

    always_ff @(posedge aclk) begin
        if (en) out_reg <= out_next;
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

/* hdl/rgbbr_checker.sv */
// Port-level checker for the RGB brightness rescaler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rgbbr_port_checker
    import rgbbr_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire rgbbr_in_t  s_data,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire rgbbr_out_t m_data
);
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "output moved in stall")
    `ASSERT_CLK(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready), "ready off stall rule")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")
    `ASSERT_CLK(a_stall_no_input, aclk, aresetn, m_valid && !m_ready |-> !s_ready, "input taken in stall")
endmodule

bind rgb_brightness_rescale_top rgbbr_port_checker u_rgbbr_port_checker (.*);
`default_nettype wire

/* test/rgbbr_checker.sv */
// Checker for the RGB brightness rescaler: predicts colors and compares outputs.
`timescale 1ns / 1ps
module rgbbr_checker
    import rgbbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  rgbbr_in_t  s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  rgbbr_out_t m_data,
    output int         fail_count,
    output int         pending
);
    rgbbr_out_t expected_colors[$];

    function automatic rgbbr_out_t rescale_color(rgbbr_in_t px);
        longint unsigned r, g, b, v, mx, mn, d, hue, sector, k, den, p, q, t;
        rgbbr_out_t res;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        v = px.brightness;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) begin
            res.red_out   = COMPONENT_BITS'(v);
            res.green_out = COMPONENT_BITS'(v);
            res.blue_out  = COMPONENT_BITS'(v);
            return res;
        end
        // red wins ties, then green
        if (mx == r) begin
            if (g >= b) hue = (60 * (g - b)) / d;
            else hue = 360 - ((60 * (b - g) + d - 1) / d);
        end else if (mx == g) begin
            hue = (120 * d + 60 * b - 60 * r) / d;
        end else begin
            hue = (240 * d + 60 * r - 60 * g) / d;
        end
        hue = hue % 360;
        sector = hue / 60;
        k = hue % 60;
        den = 60 * mx;
        p = (v * mn) / mx;
        q = (v * (den - d * k)) / den;
        t = (v * (den - d * (60 - k))) / den;
        case (sector)
            1: begin
                res.red_out   = COMPONENT_BITS'(q);
                res.green_out = COMPONENT_BITS'(v);
                res.blue_out  = COMPONENT_BITS'(p);
            end
            2: begin
                res.red_out   = COMPONENT_BITS'(p);
                res.green_out = COMPONENT_BITS'(v);
                res.blue_out  = COMPONENT_BITS'(t);
            end
            3: begin
                res.red_out   = COMPONENT_BITS'(p);
                res.green_out = COMPONENT_BITS'(q);
                res.blue_out  = COMPONENT_BITS'(v);
            end
            4: begin
                res.red_out   = COMPONENT_BITS'(t);
                res.green_out = COMPONENT_BITS'(p);
                res.blue_out  = COMPONENT_BITS'(v);
            end
            5: begin
                res.red_out   = COMPONENT_BITS'(v);
                res.green_out = COMPONENT_BITS'(p);
                res.blue_out  = COMPONENT_BITS'(q);
            end
            default: begin
                res.red_out   = COMPONENT_BITS'(v);
                res.green_out = COMPONENT_BITS'(t);
                res.blue_out  = COMPONENT_BITS'(p);
            end
        endcase
        return res;
    endfunction

    initial fail_count = 0;
    assign pending = expected_colors.size();

    always @(posedge aclk) begin
        rgbbr_out_t want;
        int         errs;
        errs = 0;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_colors.push_back(rescale_color(s_data));
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected output %h", $time, m_data);
                    errs++;
                end else begin
                    want = expected_colors.pop_front();
                    if (m_data.red_out !== want.red_out) begin
                        $display("%0t: red expected %0d actual %0d",
                                 $time, want.red_out, m_data.red_out);
                        errs++;
                    end
                    if (m_data.green_out !== want.green_out) begin
                        $display("%0t: green expected %0d actual %0d",
                                 $time, want.green_out, m_data.green_out);
                        errs++;
                    end
                    if (m_data.blue_out !== want.blue_out) begin
                        $display("%0t: blue expected %0d actual %0d",
                                 $time, want.blue_out, m_data.blue_out);
                        errs++;
                    end
                end
            end
        end
        if (errs != 0) fail_count <= fail_count + errs;
    end
endmodule

/* test/testbench.sv */
// Top of the RGB brightness rescaler testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
    import rgbbr_pkg::*;

    localparam int DRAIN_CYCLES = COMPONENT_BITS + 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    rgbbr_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    rgbbr_out_t m_data;
    int         fail_count;
    int         pending;
    int         cycle_count;
    bit         stall_free;

    rgb_brightness_rescale_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rgbbr_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Abort the run if the block hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: hold ready low for a random number of cycles per transaction,
    // except during stretches where stalls are switched off.
    initial begin
        int gap;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            gap = stall_free ? 0 : $urandom_range(0, 16);
            repeat (gap) begin
                @(negedge aclk);
                m_ready <= 0;
            end
            @(negedge aclk);
            m_ready <= 1;
            // advance until an output transaction moves
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Present one pixel and hold it until accepted; keep valid high if no gap follows.
    task automatic send_pixel(input rgbbr_in_t px, input int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 0;
        end
        @(negedge aclk);
        s_valid <= 1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic rgbbr_in_t make_pixel(int r, int g, int b, int v);
        rgbbr_in_t px;
        px.red_in     = COMPONENT_BITS'(r);
        px.green_in   = COMPONENT_BITS'(g);
        px.blue_in    = COMPONENT_BITS'(b);
        px.brightness = COMPONENT_BITS'(v);
        return px;
    endfunction

    // Random pixel: half the time full range, else near-grey or with two equal channels.
    function automatic rgbbr_in_t random_pixel();
        rgbbr_in_t px;
        int base;
        px = $urandom;
        case ($urandom_range(0, 5))
            0: begin
                base = $urandom_range(0, 250);
                px.red_in   = COMPONENT_BITS'(base + $urandom_range(0, 5));
                px.green_in = COMPONENT_BITS'(base + $urandom_range(0, 5));
                px.blue_in  = COMPONENT_BITS'(base + $urandom_range(0, 5));
            end
            1: px.green_in = px.red_in;
            2: px.blue_in = px.green_in;
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        rgbbr_in_t directed[$];
        int gap;
        s_valid = 0;
        s_data = '0;
        stall_free = 0;
        aresetn = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Cover black, white, grey, each sector, ties and the wrap to 359.
        directed = '{make_pixel(0, 0, 0, 255), make_pixel(255, 255, 255, 0),
                     make_pixel(128, 128, 128, 77), make_pixel(255, 0, 0, 255),
                     make_pixel(255, 255, 0, 200), make_pixel(0, 255, 0, 255),
                     make_pixel(0, 255, 255, 100), make_pixel(0, 0, 255, 255),
                     make_pixel(255, 0, 255, 255), make_pixel(255, 0, 1, 255),
                     make_pixel(255, 254, 255, 255), make_pixel(1, 0, 0, 1),
                     make_pixel(255, 255, 254, 255), make_pixel(254, 255, 255, 255),
                     make_pixel(10, 200, 90, 0), make_pixel(200, 30, 170, 128),
                     make_pixel(1, 2, 3, 255), make_pixel(255, 128, 0, 255),
                     make_pixel(0, 128, 255, 255), make_pixel(170, 85, 0, 255)};
        foreach (directed[i])
            send_pixel(directed[i], $urandom_range(0, 2));

        for (int n = 0; n < 850; n++) begin
            // drain the pipeline completely once mid-run
            if (n == 300) begin
                @(negedge aclk);
                s_valid <= 0;
                while (pending != 0) @(posedge aclk);
            end
            // back-to-back stretch with no stalls on either side
            stall_free = (n >= 500 && n < 600);
            gap = (stall_free || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            send_pixel(random_pixel(), gap);
        end
        @(negedge aclk);
        s_valid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
